>>> rtl/lshm_pkg.sv
// Shared types and constants for the light switch / hysteresis / menu block.
// No dependencies.
package lshm_pkg;

	localparam int PAGE_W    = 3;
	localparam int TARGET_W  = 2;
	localparam int VALUE_W   = 16;
	localparam int COUNT_W   = 10;
	localparam int PERSIST_W = 15;
	localparam int SAMPLE_W  = 8;

	// menu pages
	localparam logic [PAGE_W-1:0] PAGE_STATUS = 3'd0;
	localparam logic [PAGE_W-1:0] PAGE_ON     = 3'd1;
	localparam logic [PAGE_W-1:0] PAGE_OFF    = 3'd2;
	localparam logic [PAGE_W-1:0] PAGE_TIMER  = 3'd3;
	localparam logic [PAGE_W-1:0] PAGE_EDIT   = 3'd4;

	// edit targets
	localparam logic [TARGET_W-1:0] TGT_NONE = 2'd0;
	localparam logic [TARGET_W-1:0] TGT_ON   = 2'd1;
	localparam logic [TARGET_W-1:0] TGT_OFF  = 2'd2;
	localparam logic [TARGET_W-1:0] TGT_HOLD = 2'd3;

	// reset values
	localparam logic [VALUE_W-1:0]   ON_TH_RST    = 16'd200;
	localparam logic [VALUE_W-1:0]   OFF_TH_RST   = 16'd50;
	localparam logic [VALUE_W-1:0]   HOLD_RST     = 16'd1000;
	localparam logic [COUNT_W-1:0]   BL_COUNT_RST = 10'd500;
	localparam logic [COUNT_W-1:0]   TIMEOUT_RST  = 10'd50;
	localparam logic [PERSIST_W-1:0] PERSIST_MAX  = 15'd32767;

	// tiered hold-limit steps
	localparam logic signed [VALUE_W-1:0] UP_TIER_HI   = 16'sd1200;
	localparam logic signed [VALUE_W-1:0] UP_TIER_MID  = 16'sd600;
	localparam logic signed [VALUE_W-1:0] UP_TIER_LO   = 16'sd300;
	localparam logic signed [VALUE_W-1:0] DN_TIER_HI   = 16'sd1800;
	localparam logic signed [VALUE_W-1:0] DN_TIER_MID  = 16'sd850;
	localparam logic signed [VALUE_W-1:0] DN_TIER_LO   = 16'sd400;
	localparam logic [VALUE_W-1:0]        STEP_HI      = 16'd600;
	localparam logic [VALUE_W-1:0]        STEP_MID     = 16'd250;
	localparam logic [VALUE_W-1:0]        STEP_LO      = 16'd100;
	localparam logic [VALUE_W-1:0]        STEP_MIN     = 16'd10;

	typedef struct packed {
		logic [PAGE_W-1:0]   page;
		logic [TARGET_W-1:0] target;
		logic [VALUE_W-1:0]  edit;
		logic [VALUE_W-1:0]  on_th;
		logic [VALUE_W-1:0]  off_th;
		logic [VALUE_W-1:0]  hold;
		logic [COUNT_W-1:0]  bl_count;
	} menu_state_t;

	typedef struct packed {
		logic                 lamp;
		logic [PERSIST_W-1:0] persist;
	} lamp_state_t;

endpackage

>>> rtl/lshm_menu.sv
// Button edge detect, five-page menu and backlight countdown for one tick.
// Depends on lshm_pkg.
module lshm_menu
	import lshm_pkg::*;
(
	input  menu_state_t        cur,
	input  logic [2:0]         latch_cur,
	input  logic [2:0]         buttons_n,   // {prev, next, set}
	input  logic [COUNT_W-1:0] timeout,
	output menu_state_t        nxt,
	output logic [2:0]         latch_nxt,
	output logic               backlight
);

	function automatic menu_state_t do_set(menu_state_t s);
		menu_state_t r;
		r = s;
		case (s.page)
			PAGE_STATUS: r.page = PAGE_ON;
			PAGE_ON: begin
				r.edit = s.on_th; r.target = TGT_ON; r.page = PAGE_EDIT;
			end
			PAGE_OFF: begin
				r.edit = s.off_th; r.target = TGT_OFF; r.page = PAGE_EDIT;
			end
			PAGE_TIMER: begin
				r.edit = s.hold; r.target = TGT_HOLD; r.page = PAGE_EDIT;
			end
			PAGE_EDIT: begin
				if (s.target == TGT_ON) r.on_th = s.edit;
				else if (s.target == TGT_OFF) r.off_th = s.edit;
				else if (s.target == TGT_HOLD) r.hold = s.edit;
				r.page = PAGE_STATUS;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	function automatic menu_state_t do_next(menu_state_t s);
		menu_state_t r;
		logic [VALUE_W-1:0] step;
		r = s;
		if ($signed(s.edit) >= UP_TIER_HI) step = STEP_HI;
		else if ($signed(s.edit) >= UP_TIER_MID) step = STEP_MID;
		else if ($signed(s.edit) >= UP_TIER_LO) step = STEP_LO;
		else step = STEP_MIN;
		case (s.page)
			PAGE_ON:    r.page = PAGE_OFF;
			PAGE_OFF:   r.page = PAGE_TIMER;
			PAGE_TIMER: r.page = PAGE_ON;
			PAGE_EDIT: begin
				if (s.target == TGT_ON || s.target == TGT_OFF)
					r.edit = s.edit + 16'd1;
				else if (s.target == TGT_HOLD)
					r.edit = s.edit + step;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	function automatic menu_state_t do_prev(menu_state_t s);
		menu_state_t r;
		logic [VALUE_W-1:0] step;
		r = s;
		if ($signed(s.edit) >= DN_TIER_HI) step = STEP_HI;
		else if ($signed(s.edit) >= DN_TIER_MID) step = STEP_MID;
		else if ($signed(s.edit) >= DN_TIER_LO) step = STEP_LO;
		else step = STEP_MIN;
		case (s.page)
			PAGE_ON:    r.page = PAGE_TIMER;
			PAGE_OFF:   r.page = PAGE_ON;
			PAGE_TIMER: r.page = PAGE_OFF;
			PAGE_EDIT: begin
				if (s.target == TGT_ON || s.target == TGT_OFF)
					r.edit = s.edit - 16'd1;
				else if (s.target == TGT_HOLD)
					r.edit = s.edit - step;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	menu_state_t st0, st1, st2, st3;
	logic [2:0]  press;

	assign press = ~buttons_n & ~latch_cur;
	assign latch_nxt = ~buttons_n;    // pressed sets, released clears

	// buttons in order set, next, prev; an earlier wake reloads the count
	always_comb begin
		st0 = cur;
		st1 = st0;
		if (press[0]) begin
			if (st0.bl_count != '0) st1 = do_set(st0);
			st1.bl_count = timeout;
		end
		st2 = st1;
		if (press[1]) begin
			if (st1.bl_count != '0) st2 = do_next(st1);
			st2.bl_count = timeout;
		end
		st3 = st2;
		if (press[2]) begin
			if (st2.bl_count != '0) st3 = do_prev(st2);
			st3.bl_count = timeout;
		end
	end

	always_comb begin
		nxt = st3;
		backlight = (st3.bl_count != '0);
		if (backlight) nxt.bl_count = st3.bl_count - 10'd1;
		else nxt.page = PAGE_STATUS;
	end

endmodule

>>> rtl/lshm_lamp.sv
// Lamp hysteresis with persistence counter for one tick.
// Depends on lshm_pkg.
module lshm_lamp
	import lshm_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [VALUE_W-1:0]  on_th,
	input  logic [VALUE_W-1:0]  off_th,
	input  logic [VALUE_W-1:0]  hold,
	input  lamp_state_t         cur,
	output lamp_state_t         nxt
);

	logic signed [VALUE_W-1:0] samp_s;
	logic                      above, below, cond;
	logic [PERSIST_W-1:0]      persist_d;

	assign samp_s = $signed({{(VALUE_W-SAMPLE_W){1'b0}}, sample});
	assign above  = samp_s >= $signed(on_th);
	assign below  = samp_s <= $signed(off_th);
	assign cond   = (above && !cur.lamp) || (below && cur.lamp);

	always_comb begin
		if (!cond) persist_d = '0;
		else if (cur.persist < PERSIST_MAX) persist_d = cur.persist + 15'd1;
		else persist_d = cur.persist;
	end

	always_comb begin
		nxt.persist = persist_d;
		nxt.lamp    = cur.lamp;
		// negative hold limit makes this always true
		if ($signed({1'b0, persist_d}) > $signed(hold)) begin
			if (above) nxt.lamp = 1'b1;
			else if (below) nxt.lamp = 1'b0;
		end
	end

endmodule

>>> rtl/light_switch_hysteresis_menu.sv
// Top level of the light switch block; depends on lshm_pkg, lshm_menu, lshm_lamp.
// The tick is held in the input register and moves into the result register when advance is high.
// Throughput: one tick per cycle while the output is not stalled; the input register is freed whenever the result
// register is empty or being taken in the same cycle.
// Reset (arst_n low): thresholds 200/50, hold limit 1000, backlight count 500,
// timeout 50, page 0, lamp off, no transactions pending.
module light_switch_hysteresis_menu
	import lshm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [COUNT_W-1:0]   cfg_write_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 set_button_n,
	input  logic                 next_button_n,
	input  logic                 prev_button_n,
	input  logic [SAMPLE_W-1:0]  light_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 lamp_on,
	output logic                 backlight_on,
	output logic [PAGE_W-1:0]    menu_page,
	output logic signed [VALUE_W-1:0] edit_value,
	output logic [PERSIST_W-1:0] persist_count
);

	logic [COUNT_W-1:0]  timeout_q;
	menu_state_t         menu_q, menu_d;
	lamp_state_t         lamp_q, lamp_d;
	logic [2:0]          latch_q, latch_d;
	logic                backlight_d;

	logic                valid_s1;
	logic [2:0]          buttons_n_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic                valid_s2;
	logic                lamp_s2, backlight_s2;
	logic [PAGE_W-1:0]   page_s2;
	logic [VALUE_W-1:0]  edit_s2;
	logic [PERSIST_W-1:0] persist_s2;

	logic                accept, advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	lshm_menu u_menu (
		.cur       (menu_q),
		.latch_cur (latch_q),
		.buttons_n (buttons_n_s1),
		.timeout   (timeout_q),
		.nxt       (menu_d),
		.latch_nxt (latch_d),
		.backlight (backlight_d)
	);

	// lamp sees thresholds as edited in this same tick
	lshm_lamp u_lamp (
		.sample (sample_s1),
		.on_th  (menu_d.on_th),
		.off_th (menu_d.off_th),
		.hold   (menu_d.hold),
		.cur    (lamp_q),
		.nxt    (lamp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_write_en) begin
			timeout_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q.page     <= PAGE_STATUS;
			menu_q.target   <= TGT_NONE;
			menu_q.edit     <= '0;
			menu_q.on_th    <= ON_TH_RST;
			menu_q.off_th   <= OFF_TH_RST;
			menu_q.hold     <= HOLD_RST;
			menu_q.bl_count <= BL_COUNT_RST;
			lamp_q          <= '0;
			latch_q         <= '0;
		end else if (advance) begin
			menu_q  <= menu_d;
			lamp_q  <= lamp_d;
			latch_q <= latch_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buttons_n_s1 <= {prev_button_n, next_button_n, set_button_n};
			sample_s1    <= light_sample;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lamp_s2      <= lamp_d.lamp;
			backlight_s2 <= backlight_d;
			page_s2      <= menu_d.page;
			edit_s2      <= menu_d.edit;
			persist_s2   <= lamp_d.persist;
		end
	end

	assign out_valid     = valid_s2;
	assign lamp_on       = lamp_s2;
	assign backlight_on  = backlight_s2;
	assign menu_page     = page_s2;
	assign edit_value    = $signed(edit_s2);
	assign persist_count = persist_s2;

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed tick did not produce a result");

	a_dark_page: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !backlight_d |=> menu_page == PAGE_STATUS && !backlight_on)
		else $error("backlight off but menu not on status page");

	a_persist_copy: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> persist_count == lamp_q.persist && lamp_on == lamp_q.lamp)
		else $error("result disagrees with lamp state");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall raised with empty input register");

endmodule
